/* sv/mlbd_pkg.sv */
// Shared types and constants of the magic/length byte deframer.
// Holds the result item type, the configuration register indexes and the
// first byte classification; no dependencies.
package mlbd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 10;

  // Configuration register indexes.
  localparam logic CFG_FRAMING_MODE = 1'b0;
  localparam logic CFG_MAGIC_VALUE  = 1'b1;

  // Framing modes.
  localparam logic MODE_LENGTH    = 1'b0;
  localparam logic MODE_DELIMITED = 1'b1;

  // Byte values that make a bad start for a text packet.
  localparam logic [ByteW-1:0] CHR_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CHR_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CHR_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CHR_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CHR_SPACE = 8'h20;

  typedef struct packed {
    logic bad;
    logic binary;
  } first_flags_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [IdxW-1:0]  byte_index;
    logic             first_of_packet;
    logic             last_of_packet;
    logic             binary_packet;
    logic             bad_start;
  } result_t;

  // Classifies the first byte of a packet.
  function automatic first_flags_t flags_of(input logic [ByteW-1:0] b);
    first_flags_t f;
    f.binary = b[ByteW-1];
    f.bad    = !b[ByteW-1] && (b == CHR_NUL || b == CHR_SPACE || b == CHR_CR ||
                               b == CHR_LF || b == CHR_TAB);
    return f;
  endfunction

endpackage

/* sv/magic_length_byte_deframer.sv */
// Top level of the magic/length byte deframer.
// Depends on mlbd_pkg, mlbd_framer and mlbd_out_buf.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+---------------------------------------
//   in       | in_valid_i / in_stall_o   | rx_byte_i
//   out      | out_valid_o / out_stall_i | payload_byte_o, byte_index_o, flags
//   config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One byte item is taken per cycle while in_stall_o is low; its result
// item, if any, is registered into the output buffer on the next cycle.
// The framing state updates in the same cycle a byte is accepted, which is
// what allows a byte in every cycle.
// A two-entry output buffer decouples the sides: in_stall_o rises only when
// both entries hold results, and it comes straight from a register.
// Reset clears the framing state, both configuration registers and the buffer.
module magic_length_byte_deframer
  import mlbd_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic             first_of_packet_o,
  output logic             last_of_packet_o,
  output logic             binary_packet_o,
  output logic             bad_start_o
);

  logic    accept;
  logic    res_vld;
  logic    buf_full;
  result_t res;
  result_t out_data;

  // A byte is taken whenever the output buffer still has a free entry.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  mlbd_framer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  mlbd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_vld),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign payload_byte_o    = out_data.payload_byte;
  assign byte_index_o      = out_data.byte_index;
  assign first_of_packet_o = out_data.first_of_packet;
  assign last_of_packet_o  = out_data.last_of_packet;
  assign binary_packet_o   = out_data.binary_packet;
  assign bad_start_o       = out_data.bad_start;

  // The first byte of a packet always sits at index zero.
  a_first_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_packet_o |-> byte_index_o == '0)
    else $error("first byte of packet at nonzero index");

endmodule

/* sv/mlbd_framer.sv */
// Framing state machine and configuration registers of the deframer.
// Depends on mlbd_pkg; produces at most one result item per accepted byte.
module mlbd_framer
  import mlbd_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             res_vld_o,
  output result_t          res_o
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [IW-1:0]    wi_q, wi_d;
  first_flags_t     flags_q, flags_d;
  logic             mode_q;
  logic [ByteW-1:0] magic_q;

  logic             emit;
  logic             last;
  logic             idx_zero;
  logic [IW-1:0]    wi_next;
  first_flags_t     flags_cur;

  assign idx_zero  = (wi_q == '0);
  assign wi_next   = (wi_q == LastIdx) ? '0 : wi_q + IW'(1);
  assign flags_cur = idx_zero ? flags_of(rx_byte_i) : flags_q;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    wi_d    = wi_q;
    emit    = 1'b0;
    last    = 1'b0;
    if (mode_q == MODE_DELIMITED) begin
      emit = 1'b1;
      last = (rx_byte_i == CHR_NUL);
      wi_d = last ? '0 : wi_next;
    end else begin
      unique case (phase_q)
        PH_SIZE: begin
          rem_d   = rx_byte_i;
          wi_d    = '0;
          phase_d = (rx_byte_i == '0) ? PH_HUNT : PH_DATA;
        end
        PH_DATA: begin
          emit = 1'b1;
          last = (rem_q <= ByteW'(1));
          wi_d = wi_next;
          rem_d = last ? '0 : rem_q - ByteW'(1);
          if (last) begin
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = (rx_byte_i == magic_q) ? PH_SIZE : PH_HUNT;
        end
      endcase
    end
    flags_d = emit ? flags_cur : flags_q;
  end

  always_comb begin
    res_vld_o             = accept_i && emit;
    res_o.payload_byte    = rx_byte_i;
    res_o.byte_index      = IdxW'(wi_q);
    res_o.first_of_packet = idx_zero;
    res_o.last_of_packet  = last;
    res_o.binary_packet   = flags_cur.binary;
    res_o.bad_start       = flags_cur.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      rem_q   <= '0;
      wi_q    <= '0;
      flags_q <= '0;
      mode_q  <= MODE_LENGTH;
      magic_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAMING_MODE: mode_q  <= cfg_wdata_i[0];
          CFG_MAGIC_VALUE:  magic_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        wi_q    <= wi_d;
        flags_q <= flags_d;
      end
    end
  end

  // A frame in its payload phase always has bytes left to deliver.
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("payload phase with no bytes remaining");

  // The write index stays inside the buffer.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= LastIdx)
    else $error("write index beyond buffer depth");

  // A size byte always restarts the index at zero.
  a_size_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && mode_q == MODE_LENGTH && phase_q == PH_SIZE |=> wi_q == '0)
    else $error("index not restarted after size byte");

endmodule

/* sv/mlbd_out_buf.sv */
// Two-entry output buffer (output register plus skid register).
// Depends on mlbd_pkg for the result item type.
module mlbd_out_buf
  import mlbd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_vld_q, skid_vld_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          main_vld_q <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (!main_vld_q || pop) begin
        main_vld_q <= push_i;
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (!main_vld_q || pop) begin
      if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  // The skid entry only fills behind a held output entry.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry valid with empty output entry");

  // Nothing is pushed while both entries are occupied.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(skid_vld_q && push_i))
    else $error("push into full output buffer");

endmodule
